[design/gtp_pkg.sv]
// Shared types and constants for the gradient test-pattern pixel generator.
// Used by gtp_front, gtp_div_stage and gradient_test_pattern_pixel.
package gtp_pkg;

   localparam int MAX_DIM    = 2048;
   localparam int DIM_W      = 12;
   localparam int COORD_W    = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int RED_NUM_W  = 19;   // 255 * x
   localparam int BLU_NUM_W  = 31;   // 255 * (x*x + y*y)
   localparam int SQ_W       = 22;   // x*x
   localparam int SUM_W      = 23;   // x*x + y*y
   localparam int DSQ_W      = 23;   // w*w with w up to MAX_DIM
   localparam int DEN_W      = 24;   // w*w + h*h
   localparam int DIV_STAGES = 8;    // one quotient bit per stage
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   // Item state while it walks the divider stages
   typedef struct packed {
      logic                 oof;
      logic [RED_NUM_W-1:0] red_rem;
      logic [RED_NUM_W-1:0] grn_rem;
      logic [BLU_NUM_W-1:0] blu_rem;
      logic [7:0]           red_q;
      logic [7:0]           grn_q;
      logic [7:0]           blu_q;
   } gtp_div_type;

   // Saturate a programmed dimension to the supported maximum
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

endpackage

[design/gtp_front.sv]
// Front pipeline: frame check, scaled numerators and squared distance.
// Four register stages; depends on gtp_pkg.
module gtp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [gtp_pkg::COORD_W-1:0]  in_x,
   input  logic [gtp_pkg::COORD_W-1:0]  in_y,
   input  logic [gtp_pkg::DIM_W-1:0]    eff_w,
   input  logic [gtp_pkg::DIM_W-1:0]    eff_h,
   output logic                         out_valid,
   input  logic                         out_ready,
   output gtp_pkg::gtp_div_type         out_data
);
   import gtp_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [COORD_W-1:0]   x1_ff, y1_ff;
   logic                 oof1_ff, oof1_in;
   logic [RED_NUM_W-1:0] rnum2_ff, gnum2_ff, rnum2_in, gnum2_in;
   logic [SQ_W-1:0]      xsq2_ff, ysq2_ff, xsq2_in, ysq2_in;
   logic                 oof2_ff;
   logic [RED_NUM_W-1:0] rnum3_ff, gnum3_ff;
   logic [SUM_W-1:0]     sum3_ff, sum3_in;
   logic                 oof3_ff;
   logic [RED_NUM_W-1:0] rnum4_ff, gnum4_ff;
   logic [BLU_NUM_W-1:0] bnum4_ff, bnum4_in;
   logic                 oof4_ff;

   // A stage takes a new item when empty or when its successor moves
   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      oof1_in  = ({1'b0, in_x} >= eff_w) || ({1'b0, in_y} >= eff_h);
      rnum2_in = RED_NUM_W'({x1_ff, 8'b0}) - RED_NUM_W'(x1_ff);
      gnum2_in = RED_NUM_W'({y1_ff, 8'b0}) - RED_NUM_W'(y1_ff);
      xsq2_in  = SQ_W'(x1_ff) * SQ_W'(x1_ff);
      ysq2_in  = SQ_W'(y1_ff) * SQ_W'(y1_ff);
      sum3_in  = SUM_W'(xsq2_ff) + SUM_W'(ysq2_ff);
      bnum4_in = BLU_NUM_W'({sum3_ff, 8'b0}) - BLU_NUM_W'(sum3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         x1_ff   <= in_x;
         y1_ff   <= in_y;
         oof1_ff <= oof1_in;
      end
      if (rdy2) begin
         rnum2_ff <= rnum2_in;
         gnum2_ff <= gnum2_in;
         xsq2_ff  <= xsq2_in;
         ysq2_ff  <= ysq2_in;
         oof2_ff  <= oof1_ff;
      end
      if (rdy3) begin
         rnum3_ff <= rnum2_ff;
         gnum3_ff <= gnum2_ff;
         sum3_ff  <= sum3_in;
         oof3_ff  <= oof2_ff;
      end
      if (rdy4) begin
         rnum4_ff <= rnum3_ff;
         gnum4_ff <= gnum3_ff;
         bnum4_ff <= bnum4_in;
         oof4_ff  <= oof3_ff;
      end
   end

   assign out_valid = v4_ff;

   always_comb begin
      out_data         = '0;
      out_data.oof     = oof4_ff;
      out_data.red_rem = rnum4_ff;
      out_data.grn_rem = gnum4_ff;
      out_data.blu_rem = bnum4_ff;
   end

endmodule

[design/gtp_div_stage.sv]
// One restoring-division step for red, green and blue: one quotient bit each.
// Registered stage with its own valid and ready; depends on gtp_pkg.
module gtp_div_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                bit_idx,
   input  logic [gtp_pkg::DIM_W-1:0] eff_w,
   input  logic [gtp_pkg::DIM_W-1:0] eff_h,
   input  logic [gtp_pkg::DEN_W-1:0] denom,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  gtp_pkg::gtp_div_type      in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output gtp_pkg::gtp_div_type      out_data
);
   import gtp_pkg::*;

   logic                   valid_ff;
   gtp_div_type            data_ff, data_in;
   logic [RED_NUM_W:0]     red_dv, grn_dv;
   logic [BLU_NUM_W:0]     blu_dv;
   logic [7:0]             qbit;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      red_dv  = (RED_NUM_W + 1)'(eff_w) << bit_idx;
      grn_dv  = (RED_NUM_W + 1)'(eff_h) << bit_idx;
      blu_dv  = (BLU_NUM_W + 1)'(denom) << bit_idx;
      qbit    = 8'd1 << bit_idx;
      data_in = in_data;
      if ({1'b0, in_data.red_rem} >= red_dv) begin
         data_in.red_rem = in_data.red_rem - red_dv[RED_NUM_W-1:0];
         data_in.red_q   = in_data.red_q | qbit;
      end
      if ({1'b0, in_data.grn_rem} >= grn_dv) begin
         data_in.grn_rem = in_data.grn_rem - grn_dv[RED_NUM_W-1:0];
         data_in.grn_q   = in_data.grn_q | qbit;
      end
      if ({1'b0, in_data.blu_rem} >= blu_dv) begin
         data_in.blu_rem = in_data.blu_rem - blu_dv[BLU_NUM_W-1:0];
         data_in.blu_q   = in_data.blu_q | qbit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/gradient_test_pattern_pixel.sv]
// Gradient test-pattern pixel generator, top level.
// Pipeline: 12 register stages, 4 front and 8 divider, the first loaded at the edge
//   that accepts its item; throughput one item per clock while the result stream
//   is not stalled.
// Every stage carries its own valid bit and fills bubbles, so a stalled
//   result does not block items behind it while space remains.
// Reset (synchronous, active high) empties the pipeline and sets the frame to 640x480.
module gradient_test_pattern_pixel (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // [10:0] pixel_x, [21:11] pixel_y
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // [31:0] pixel_word
   output logic                             rsp_tuser,  // [0] out_of_frame
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtp_pkg::DIM_W-1:0]        csr_data
);
   import gtp_pkg::*;

   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [DSQ_W-1:0] wsq_ff, hsq_ff;
   logic [DEN_W-1:0] denom_ff;

   logic        stg_valid [0:DIV_STAGES];
   logic        stg_ready [0:DIV_STAGES];
   gtp_div_type stg_data  [0:DIV_STAGES];
   gtp_div_type last_data;

   // Configuration: always ready, hold the two frame dimensions
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(640);
         frame_height_ff <= DIM_W'(480);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   assign eff_w = eff_dim(frame_width_ff);
   assign eff_h = eff_dim(frame_height_ff);

   // Blue divisor w*w + h*h, registered through wsq_ff/hsq_ff and then denom_ff; it settles
   // before any newly accepted item reaches the first divider stage
   always_ff @(posedge clock) begin
      wsq_ff   <= DSQ_W'(eff_w) * DSQ_W'(eff_w);
      hsq_ff   <= DSQ_W'(eff_h) * DSQ_W'(eff_h);
      denom_ff <= DEN_W'(wsq_ff) + DEN_W'(hsq_ff);
   end

   // Front: frame check, 255*x, 255*y, 255*(x*x + y*y)
   gtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[10:0]),
      .in_y      (req_tdata[21:11]),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   // Divider chain: quotient bit 7 first, bit 0 last
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      gtp_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .bit_idx   (3'(DIV_STAGES - 1 - k)),
         .eff_w     (eff_w),
         .eff_h     (eff_h),
         .denom     (denom_ff),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   // Last stage register drives the result stream; drop the color when out of frame
   assign last_data             = stg_data[DIV_STAGES];
   assign rsp_tvalid            = stg_valid[DIV_STAGES];
   assign stg_ready[DIV_STAGES] = rsp_tready;
   assign rsp_tuser             = last_data.oof;
   assign rsp_tdata = last_data.oof ? 32'd0
                    : {ALPHA_OPAQUE, last_data.red_q, last_data.grn_q, last_data.blu_q};

endmodule

[design/gtp_checker.sv]
// Port-level checks for gradient_test_pattern_pixel, attached by bind.
// Depends on the top level's ports only.
module gtp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Out-of-frame items carry a zero word
   a_oof_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("out-of-frame item with nonzero word");

   // In-frame items are opaque and red never reaches full scale
   a_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:24] == 8'hFF && rsp_tdata[23:16] != 8'hFF)
      else $error("bad in-frame word");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind gradient_test_pattern_pixel gtp_checker u_gtp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
